@@ rtl/thp_pkg.sv @@
// ----------------------------------------------------------------------------
// Transport header parser package
// Shared types, protocol numbers and GRE constants for the parser.
// ----------------------------------------------------------------------------
package thp_pkg;

    localparam int WINDOW_BYTES_DEF = 20;

    localparam logic [15:0] ERSPAN2_RESET = 16'h88BE;

    localparam logic [7:0] PROTO_ICMP   = 8'd1;
    localparam logic [7:0] PROTO_IPIP   = 8'd4;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [7:0] PROTO_IPV6   = 8'd41;
    localparam logic [7:0] PROTO_GRE    = 8'd47;
    localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

    localparam logic [15:0] GRE_FLAG_CSUM  = 16'h8000;
    localparam logic [15:0] GRE_FLAG_KEY   = 16'h2000;
    localparam logic [15:0] GRE_FLAG_SEQ   = 16'h1000;
    localparam logic [15:0] GRE_VER_MASK   = 16'h0007;
    localparam logic [15:0] GRE_FLAG_ACK   = 16'h0080;
    localparam logic [15:0] GRE_VER_PPTP   = 16'h0001;
    localparam logic [15:0] GRE_PROTO_PPP  = 16'h880B;
    localparam logic [15:0] GRE_PROTO_ERSPAN3 = 16'h22EB;
    localparam logic [15:0] GRE_PROTO_TEB  = 16'h6558;
    localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6     = 16'h86DD;

    typedef enum logic [2:0] {
        OUTCOME_DONE        = 3'd0,
        OUTCOME_SKIP_SHORT  = 3'd1,
        OUTCOME_ERROR       = 3'd2,
        OUTCOME_REPARSE_IP  = 3'd3,
        OUTCOME_REPARSE_ETH = 3'd4,
        OUTCOME_REPARSE_ETYPE = 3'd5
    } outcome_t;

    typedef enum logic [1:0] {
        FLOW_UDP   = 2'd0,
        FLOW_TCP   = 2'd1,
        FLOW_ICMP  = 2'd2,
        FLOW_OTHER = 2'd3
    } flow_kind_t;

    typedef enum logic [1:0] {
        TUNNEL_NONE = 2'd0,
        TUNNEL_IPV6 = 2'd1,
        TUNNEL_IPIP = 2'd2,
        TUNNEL_GRE  = 2'd3
    } tunnel_kind_t;

    typedef struct packed {
        tunnel_kind_t tunnel_kind;
        logic [15:0]  next_ethertype;
        logic [15:0]  payload_size;
        logic [15:0]  header_len;
        logic         flush;
        logic [7:0]   tcp_flags;
        logic [15:0]  dport;
        logic [15:0]  sport;
        outcome_t     outcome;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    function automatic logic [15:0] sub_clamp(input logic [15:0] a, input logic [15:0] b);
        return (a > b) ? (a - b) : 16'd0;
    endfunction

endpackage

@@ rtl/transport_header_parser_unit.sv @@
// ----------------------------------------------------------------------------
// Transport header parser unit
// Parses UDP, TCP, ICMP, IP tunnel and GRE headers from a byte stream and
// gives one summary per packet on its last byte.
// ----------------------------------------------------------------------------
// Throughput: one byte per clock cycle unless a pending summary waits on a full
// output register; results are taken at one per cycle. The last byte updates the
// window and counters, then the parse stage result is registered for output.
// Reset (aresetn, synchronous, active low) clears the window, the byte count,
// the held protocol and length, and restores the ERSPAN II ethertype.
module transport_header_parser_unit
    import thp_pkg::*;
#(
    parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // data_byte [7:0], ip_proto [15:8], ip_payload_len [31:16]
    input  logic [31:0]          s_tdata,
    // first [0]
    input  logic [0:0]           s_tuser,
    input  logic                 s_tlast,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // outcome [2:0], sport [18:3], dport [34:19], tcp_flags [42:35],
    // flush [43], header_len [59:44], payload_size [75:60],
    // next_ethertype [91:76], tunnel_kind [93:92], zero padding above
    output logic [M_TDATA_W-1:0] m_tdata,
    // flow_kind [1:0]
    output logic [1:0]           m_tuser
);

    logic [15:0] erspan2_reg;
    logic [15:0] byte_count_reg, byte_count_next;
    logic        restart_reg;
    logic [7:0]  proto_reg;
    logic [15:0] plen_reg;
    logic [7:0]  win_reg [WINDOW_BYTES];
    logic        pend_reg, pend_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_res_reg, res;
    flow_kind_t  out_kind_reg, kind;

    logic        s_acc;
    logic        move;
    logic [15:0] base;

    assign s_acc = s_tvalid && s_tready;
    // A pending summary advances when the output register is free or being drained.
    assign move     = pend_reg && (!out_valid_reg || m_tready);
    assign s_tready = !pend_reg || move;

    assign base = (s_tuser[0] || restart_reg) ? 16'd0 : byte_count_reg;
    assign byte_count_next = (base == 16'hFFFF) ? base : base + 16'd1;

    always_comb begin
        pend_next = pend_reg;
        if (move) begin
            pend_next = 1'b0;
        end
        if (s_acc && s_tlast) begin
            pend_next = 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (move) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            erspan2_reg    <= ERSPAN2_RESET;
            byte_count_reg <= 16'd0;
            restart_reg    <= 1'b0;
            proto_reg      <= 8'd0;
            plen_reg       <= 16'd0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < WINDOW_BYTES; i++) begin
                win_reg[i] <= 8'd0;
            end
        end else begin
            if (cfg_wr_en) begin
                erspan2_reg <= cfg_wr_data;
            end
            if (s_acc) begin
                byte_count_reg <= byte_count_next;
                restart_reg    <= s_tlast;
                if (s_tuser[0]) begin
                    proto_reg <= s_tdata[15:8];
                    plen_reg  <= s_tdata[31:16];
                end
                for (int i = 0; i < WINDOW_BYTES; i++) begin
                    if (base == 16'(i)) begin
                        win_reg[i] <= s_tdata[7:0];
                    end
                end
            end
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            out_res_reg  <= res;
            out_kind_reg <= kind;
        end
    end

    // Parse stage: reads the window and counters left by the last byte.
    logic [15:0] c, len;
    logic [15:0] w0, w2, w4, gre_call;
    logic [15:0] tcp_hl, ip4_hl, gre_off, pptp_off;
    logic [1:0]  gre_n;

    always_comb begin
        c   = byte_count_reg;
        len = plen_reg;
        w0  = {win_reg[0], win_reg[1]};
        w2  = {win_reg[2], win_reg[3]};
        w4  = {win_reg[4], win_reg[5]};
        tcp_hl = {10'd0, win_reg[12][7:4], 2'b00};
        ip4_hl = {10'd0, win_reg[0][3:0], 2'b00};
        gre_n  = 2'({1'b0, (w0 & GRE_FLAG_CSUM) != 16'd0})
               + 2'({1'b0, (w0 & GRE_FLAG_KEY) != 16'd0})
               + 2'({1'b0, (w0 & GRE_FLAG_SEQ) != 16'd0});
        gre_off  = 16'd4 + {12'd0, gre_n, 2'b00};
        pptp_off = gre_off + 16'd4;
        case (gre_n)
            2'd0:    gre_call = {win_reg[6], win_reg[7]};
            2'd1:    gre_call = {win_reg[10], win_reg[11]};
            2'd2:    gre_call = {win_reg[14], win_reg[15]};
            default: gre_call = {win_reg[18], win_reg[19]};
        endcase

        case (proto_reg)
            PROTO_UDP:                 kind = FLOW_UDP;
            PROTO_TCP:                 kind = FLOW_TCP;
            PROTO_ICMP, PROTO_ICMPV6:  kind = FLOW_ICMP;
            default:                   kind = FLOW_OTHER;
        endcase

        res = '0;
        if (len > c) begin
            res.outcome = OUTCOME_ERROR;
        end else begin
            case (proto_reg)
                PROTO_UDP: begin
                    if (c < 16'd8) begin
                        res.outcome = OUTCOME_SKIP_SHORT;
                    end else if (w4 < 16'd8) begin
                        res.outcome = OUTCOME_ERROR;
                    end else begin
                        res.sport      = w0;
                        res.dport      = w2;
                        res.header_len = 16'd8;
                        res.payload_size = ((w4 - 16'd8) > sub_clamp(len, 16'd8))
                                         ? sub_clamp(len, 16'd8) : (w4 - 16'd8);
                    end
                end
                PROTO_TCP: begin
                    if (c < 16'd20) begin
                        res.outcome = OUTCOME_SKIP_SHORT;
                    end else if (tcp_hl < 16'd20) begin
                        res.outcome = OUTCOME_ERROR;
                    end else if (tcp_hl > c) begin
                        res.outcome = OUTCOME_SKIP_SHORT;
                    end else begin
                        res.sport        = w0;
                        res.dport        = w2;
                        res.tcp_flags    = win_reg[13];
                        res.flush        = win_reg[13][0] | win_reg[13][2];
                        res.header_len   = tcp_hl;
                        res.payload_size = sub_clamp(len, tcp_hl);
                    end
                end
                PROTO_ICMP, PROTO_ICMPV6: begin
                    if (c < 16'd8) begin
                        res.outcome = OUTCOME_SKIP_SHORT;
                    end else begin
                        res.dport        = w0;
                        res.header_len   = 16'd8;
                        res.payload_size = sub_clamp(len, 16'd8);
                    end
                end
                PROTO_IPV6: begin
                    if (c < 16'd40) begin
                        res.outcome = OUTCOME_SKIP_SHORT;
                    end else begin
                        res.outcome     = OUTCOME_REPARSE_IP;
                        res.tunnel_kind = TUNNEL_IPV6;
                    end
                end
                PROTO_IPIP: begin
                    if (c < 16'd20 || c < ip4_hl) begin
                        res.outcome = OUTCOME_SKIP_SHORT;
                    end else begin
                        res.outcome     = OUTCOME_REPARSE_IP;
                        res.tunnel_kind = TUNNEL_IPIP;
                    end
                end
                PROTO_GRE: begin
                    if (c < 16'd4 || gre_off > c) begin
                        res.outcome = OUTCOME_SKIP_SHORT;
                    end else if ((w0 & GRE_VER_MASK) == GRE_VER_PPTP) begin
                        // PPTP: call id follows the payload length word.
                        if (pptp_off > c) begin
                            res.outcome = OUTCOME_SKIP_SHORT;
                        end else if (w2 != GRE_PROTO_PPP) begin
                            res.outcome = OUTCOME_ERROR;
                            res.dport   = gre_call;
                        end else if ((w0 & GRE_FLAG_ACK) != 16'd0) begin
                            if (pptp_off + 16'd4 > c) begin
                                res.outcome = OUTCOME_SKIP_SHORT;
                            end else begin
                                res.dport        = gre_call;
                                res.header_len   = pptp_off + 16'd4;
                                res.payload_size = sub_clamp(len, pptp_off + 16'd4);
                            end
                        end else begin
                            res.dport        = gre_call;
                            res.header_len   = pptp_off;
                            res.payload_size = sub_clamp(len, pptp_off);
                        end
                    end else if (w2 == erspan2_reg) begin
                        if (gre_off + 16'd8 > c) begin
                            res.outcome = OUTCOME_SKIP_SHORT;
                        end else begin
                            res.outcome    = OUTCOME_REPARSE_ETH;
                            res.header_len = gre_off + 16'd8;
                        end
                    end else if (w2 == GRE_PROTO_ERSPAN3) begin
                        if (gre_off + 16'd20 > c) begin
                            res.outcome = OUTCOME_SKIP_SHORT;
                        end else begin
                            res.outcome    = OUTCOME_REPARSE_ETH;
                            res.header_len = gre_off + 16'd20;
                        end
                    end else if (w2 == GRE_PROTO_TEB) begin
                        res.outcome    = OUTCOME_REPARSE_ETH;
                        res.header_len = gre_off;
                    end else if (w2 == ETYPE_IPV4 || w2 == ETYPE_IPV6) begin
                        res.outcome        = OUTCOME_REPARSE_ETYPE;
                        res.header_len     = gre_off;
                        res.next_ethertype = w2;
                        res.tunnel_kind    = TUNNEL_GRE;
                    end else begin
                        res.outcome = OUTCOME_SKIP_SHORT;
                    end
                end
                default: begin
                    res.payload_size = len;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_res_reg);
    assign m_tuser  = out_kind_reg;

    // A held summary must block new bytes until the output register drains.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("byte accepted while a summary could not advance");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> pend_reg)
        else $error("last byte did not raise a pending summary");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_res_reg.outcome <= OUTCOME_REPARSE_ETYPE))
        else $error("summary outcome out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res_reg.flush) |-> (out_kind_reg == FLOW_TCP))
        else $error("flush set on a non-TCP flow");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tuser[0] && !restart_reg && byte_count_reg != 16'hFFFF)
        |=> (byte_count_reg == $past(byte_count_reg) + 16'd1))
        else $error("byte count did not advance within a packet");

endmodule
